@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define LDEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LDEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ldem_pkg.sv @@
// Package for the two-locus LD EM estimator: widths, register indexes,
// sequencer states and the shared arithmetic unit's request/response types.
package ldem_pkg;

  localparam int WORD_W   = 64;
  localparam int WIDE_W   = 128;
  localparam int OUT_FRAC = 30;

  localparam int COUNT_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 32;

  localparam logic [7:0]  ITER_LIMIT_RST = 8'd100;
  localparam logic [15:0] STOP_TOL_RST   = 16'd4295;
  localparam logic [7:0]  FLOOR_RST      = 8'd4;

  localparam logic [1:0] REG_ITER_LIMIT = 2'd0;
  localparam logic [1:0] REG_STOP_TOL   = 2'd1;
  localparam logic [1:0] REG_FLOOR      = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_P, S_Q, S_F11, S_F12, S_F21, S_F22, S_FLOOR,
    S_T1, S_T2, S_S1, S_S2, S_M1, S_M2, S_D11, S_D12, S_D21, S_D22, S_CHK,
    S_X, S_Y, S_DM1, S_DM2, S_DP, S_PP, S_QQ, S_DD, S_T, S_R2, S_DONE
  } ldem_state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  // MUL: num[63:0] * den; DIV: floor(num / den), saturating at all ones
  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [WIDE_W-1:0] num;
    logic [WORD_W-1:0] den;
  } arith_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] res;
  } arith_rsp_t;

endpackage

@@ rtl/ldem_arith.sv @@
// Shared arithmetic unit: 64x64 multiply from four 32x32 partial products,
// and a restoring 128/64 divider, one quotient bit per cycle. Uses ldem_pkg.
module ldem_arith import ldem_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  arith_op_t         op_r;
  logic [6:0]        cnt_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WIDE_W-1:0] acc_r;
  logic [WORD_W-1:0] pp_r;
  logic [1:0]        pp_sh_r;
  logic              pp_vld_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] lo_r;
  logic [WORD_W-1:0] quo_r;
  logic [WIDE_W-1:0] res_r;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [WIDE_W-1:0] acc_sum;
  logic [WORD_W-1:0] shl;
  logic              carry;
  logic              take;

  always_comb begin
    mul_a   = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    mul_b   = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    acc_sum = acc_r + (pp_vld_r ? ({64'd0, pp_r} << {pp_sh_r, 5'd0}) : '0);
    carry   = rem_r[WORD_W-1];
    shl     = {rem_r[WORD_W-2:0], lo_r[WORD_W-1]};
    take    = carry || (shl >= b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      pp_vld_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          op_r     <= req.op;
          a_r      <= req.num[WORD_W-1:0];
          b_r      <= req.den;
          cnt_r    <= '0;
          acc_r    <= '0;
          pp_vld_r <= 1'b0;
          rem_r    <= req.num[WIDE_W-1:WORD_W];
          lo_r     <= req.num[WORD_W-1:0];
          quo_r    <= '0;
          if (req.op == OP_MUL) begin
            busy_r <= 1'b1;
          end else if (req.den == '0) begin
            res_r  <= (req.num != '0) ? {64'd0, {WORD_W{1'b1}}} : '0;
            done_r <= 1'b1;
          end else if (req.num[WIDE_W-1:WORD_W] >= req.den) begin
            res_r  <= {64'd0, {WORD_W{1'b1}}};
            done_r <= 1'b1;
          end else begin
            busy_r <= 1'b1;
          end
        end
      end else if (op_r == OP_MUL) begin
        pp_r     <= WORD_W'(mul_a) * WORD_W'(mul_b);
        pp_sh_r  <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
        pp_vld_r <= (cnt_r < 7'd4);
        acc_r    <= acc_sum;
        cnt_r    <= cnt_r + 7'd1;
        if (cnt_r == 7'd4) begin
          res_r  <= acc_sum;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end else begin
        rem_r <= take ? (shl - b_r) : shl;
        lo_r  <= {lo_r[WORD_W-2:0], 1'b0};
        quo_r <= {quo_r[WORD_W-2:0], take};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          res_r  <= {64'd0, quo_r[WORD_W-2:0], take};
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

@@ rtl/two_locus_ld_em_estimator_unit.sv @@
// Two-locus LD estimator: EM over phase-unknown double heterozygotes,
// giving r-squared and D-prime. Uses ldem_pkg, ldem_arith, assert_macros.svh.
//
//   channel | dir | fields
//   in_     | in  | count_ac, count_ad, count_bc, count_bd, double_het_count
//   out_    | out | r_squared, d_prime
//   cfg_    | in  | 0 iteration_limit, 1 stop_tolerance, 2 frequency_floor
//
// One transaction in flight; in_tready is high only in the idle state.
// All multiplies and divides run on the one shared unit.
// Reset: synchronous, active low; no clearing pass.
// The output register holds a result until taken; the next result waits for it.
`include "assert_macros.svh"

module two_locus_ld_em_estimator_unit import ldem_pkg::*; #(
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // count_ac, count_ad, count_bc, count_bd, double_het_count, zero pad
  input  logic [((5*COUNT_BITS+7)/8)*8-1:0]  in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // r_squared [30:0], d_prime [62:31], zero pad
  output logic [63:0]                        out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_wdata
);

  localparam int NW   = COUNT_BITS + 3;
  localparam logic [WORD_W-1:0] ONE     = WORD_W'(1) << FRACTION_BITS;
  localparam logic [WORD_W-1:0] OUT_ONE = WORD_W'(1) << OUT_FRAC;

  logic [7:0]  iter_limit_r;
  logic [15:0] stop_tol_r;
  logic [7:0]  floor_r;

  ldem_state_t state_r, state_nxt;
  logic        launched_r;

  logic [COUNT_BITS-1:0] c11_r, c12_r, c21_r, c22_r, dh_r;
  logic [NW-1:0]         n_r;
  logic [WORD_W-1:0]     p_r, q_r, f11_r, f12_r, f21_r, f22_r;
  logic [WORD_W-1:0]     t1_r, t2_r, s1_r, s2_r, before_r, x_r, dabs_r, tmp_r;
  logic [WORD_W-1:0]     dmx_r, pp_r, qq_r, t_r;
  logic [WIDE_W-1:0]     ds1_r, ds2_r;
  logic                  xgt_r;
  logic [7:0]            iter_r;
  logic [30:0]           r2_r;
  logic [31:0]           dp_r;
  logic                  out_valid_r;
  logic [63:0]           out_data_r;

  arith_req_t arith_req;
  arith_rsp_t arith_rsp;

  logic [COUNT_BITS-1:0] in_c11, in_c12, in_c21, in_c22, in_dh;
  logic                  degenerate;
  logic                  is_arith;
  logic                  step_done;
  logic [WORD_W-1:0]     fm;
  logic [WORD_W-1:0]     quo;
  logic [WORD_W-1:0]     diff;
  logic [WORD_W-1:0]     n_w;
  logic                  out_free;
  logic [WORD_W-1:0]     floor_w;

  ldem_arith u_arith (
    .clk (clk),
    .rst_n (rst_n),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  always_comb begin
    in_c11     = in_tdata[0*COUNT_BITS +: COUNT_BITS];
    in_c12     = in_tdata[1*COUNT_BITS +: COUNT_BITS];
    in_c21     = in_tdata[2*COUNT_BITS +: COUNT_BITS];
    in_c22     = in_tdata[3*COUNT_BITS +: COUNT_BITS];
    in_dh      = in_tdata[4*COUNT_BITS +: COUNT_BITS];
    degenerate = (in_dh == '0) &&
                 (((in_c11 | in_c12) == '0) || ((in_c21 | in_c22) == '0) ||
                  ((in_c11 | in_c21) == '0) || ((in_c12 | in_c22) == '0));
    // fixed-point product, floor, saturating
    fm   = (arith_rsp.res[WIDE_W-1:WORD_W+FRACTION_BITS] != '0) ? {WORD_W{1'b1}}
           : arith_rsp.res[FRACTION_BITS +: WORD_W];
    quo  = arith_rsp.res[WORD_W-1:0];
    diff = (before_r > f11_r) ? (before_r - f11_r) : (f11_r - before_r);
    n_w  = WORD_W'(n_r);
    floor_w = WORD_W'(floor_r);
    out_free = !out_valid_r || out_tready;
  end

  // sequencer: next state and operands for the shared unit
  always_comb begin
    state_nxt     = state_r;
    is_arith      = 1'b1;
    arith_req.op  = OP_MUL;
    arith_req.num = '0;
    arith_req.den = '0;
    unique case (state_r)
      S_IDLE: begin
        is_arith = 1'b0;
        if (in_tvalid) begin
          state_nxt = degenerate ? S_DONE : S_P;
        end
      end
      S_P: begin
        arith_req.op  = OP_DIV;
        arith_req.num = (WIDE_W'(c11_r) + WIDE_W'(c12_r) + WIDE_W'(dh_r)) << FRACTION_BITS;
        arith_req.den = n_w;
        state_nxt     = S_Q;
      end
      S_Q: begin
        arith_req.op  = OP_DIV;
        arith_req.num = (WIDE_W'(c11_r) + WIDE_W'(c21_r) + WIDE_W'(dh_r)) << FRACTION_BITS;
        arith_req.den = n_w;
        state_nxt     = S_F11;
      end
      S_F11: begin
        arith_req.num = WIDE_W'(p_r);
        arith_req.den = q_r;
        state_nxt     = S_F12;
      end
      S_F12: begin
        arith_req.num = WIDE_W'(p_r);
        arith_req.den = ONE - q_r;
        state_nxt     = S_F21;
      end
      S_F21: begin
        arith_req.num = WIDE_W'(ONE - p_r);
        arith_req.den = q_r;
        state_nxt     = S_F22;
      end
      S_F22: begin
        arith_req.num = WIDE_W'(ONE - p_r);
        arith_req.den = ONE - q_r;
        state_nxt     = (iter_limit_r == '0) ? S_X : S_FLOOR;
      end
      S_FLOOR: begin
        is_arith  = 1'b0;
        state_nxt = S_T1;
      end
      S_T1: begin
        arith_req.num = WIDE_W'(f11_r);
        arith_req.den = f22_r;
        state_nxt     = S_T2;
      end
      S_T2: begin
        arith_req.num = WIDE_W'(f12_r);
        arith_req.den = f21_r;
        state_nxt     = S_S1;
      end
      S_S1: begin
        arith_req.op  = OP_DIV;
        arith_req.num = WIDE_W'(t1_r) << FRACTION_BITS;
        arith_req.den = t1_r + t2_r;
        state_nxt     = S_S2;
      end
      S_S2: begin
        arith_req.op  = OP_DIV;
        arith_req.num = WIDE_W'(t2_r) << FRACTION_BITS;
        arith_req.den = t1_r + t2_r;
        state_nxt     = S_M1;
      end
      S_M1: begin
        arith_req.num = WIDE_W'(dh_r);
        arith_req.den = s1_r;
        state_nxt     = S_M2;
      end
      S_M2: begin
        arith_req.num = WIDE_W'(dh_r);
        arith_req.den = s2_r;
        state_nxt     = S_D11;
      end
      S_D11: begin
        arith_req.op  = OP_DIV;
        arith_req.num = (WIDE_W'(c11_r) << FRACTION_BITS) + ds1_r;
        arith_req.den = n_w;
        state_nxt     = S_D12;
      end
      S_D12: begin
        arith_req.op  = OP_DIV;
        arith_req.num = (WIDE_W'(c12_r) << FRACTION_BITS) + ds2_r;
        arith_req.den = n_w;
        state_nxt     = S_D21;
      end
      S_D21: begin
        arith_req.op  = OP_DIV;
        arith_req.num = (WIDE_W'(c21_r) << FRACTION_BITS) + ds2_r;
        arith_req.den = n_w;
        state_nxt     = S_D22;
      end
      S_D22: begin
        arith_req.op  = OP_DIV;
        arith_req.num = (WIDE_W'(c22_r) << FRACTION_BITS) + ds1_r;
        arith_req.den = n_w;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        is_arith = 1'b0;
        if ((diff < WORD_W'(stop_tol_r)) ||
            (({1'b0, iter_r} + 9'd1) == {1'b0, iter_limit_r})) begin
          state_nxt = S_X;
        end else begin
          state_nxt = S_FLOOR;
        end
      end
      S_X: begin
        arith_req.num = WIDE_W'(f11_r);
        arith_req.den = f22_r;
        state_nxt     = S_Y;
      end
      S_Y: begin
        arith_req.num = WIDE_W'(f12_r);
        arith_req.den = f21_r;
        state_nxt     = S_DM1;
      end
      // D-max: with D > 0 the lesser of p(1-q), (1-p)q; else of pq, (1-p)(1-q)
      S_DM1: begin
        arith_req.num = WIDE_W'(p_r);
        arith_req.den = xgt_r ? (ONE - q_r) : q_r;
        state_nxt     = S_DM2;
      end
      S_DM2: begin
        arith_req.num = WIDE_W'(ONE - p_r);
        arith_req.den = xgt_r ? q_r : (ONE - q_r);
        state_nxt     = S_DP;
      end
      S_DP: begin
        arith_req.op  = OP_DIV;
        arith_req.num = WIDE_W'(dabs_r) << OUT_FRAC;
        arith_req.den = dmx_r;
        state_nxt     = S_PP;
      end
      S_PP: begin
        arith_req.num = WIDE_W'(p_r);
        arith_req.den = ONE - p_r;
        state_nxt     = S_QQ;
      end
      S_QQ: begin
        arith_req.num = WIDE_W'(q_r);
        arith_req.den = ONE - q_r;
        state_nxt     = S_DD;
      end
      S_DD: begin
        arith_req.num = WIDE_W'(dabs_r);
        arith_req.den = dabs_r;
        state_nxt     = S_T;
      end
      S_T: begin
        arith_req.op  = OP_DIV;
        arith_req.num = WIDE_W'(tmp_r) << FRACTION_BITS;
        arith_req.den = pp_r;
        state_nxt     = S_R2;
      end
      S_R2: begin
        arith_req.op  = OP_DIV;
        arith_req.num = WIDE_W'(t_r) << OUT_FRAC;
        arith_req.den = qq_r;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        is_arith = 1'b0;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        is_arith  = 1'b0;
        state_nxt = S_IDLE;
      end
    endcase
    step_done       = is_arith && launched_r && arith_rsp.done;
    arith_req.start = is_arith && !launched_r;
    if (is_arith && !step_done) begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (step_done) begin
        launched_r <= 1'b0;
      end else if (arith_req.start) begin
        launched_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= ITER_LIMIT_RST;
      stop_tol_r   <= STOP_TOL_RST;
      floor_r      <= FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ITER_LIMIT: iter_limit_r <= cfg_wdata[7:0];
        REG_STOP_TOL:   stop_tol_r   <= cfg_wdata;
        REG_FLOOR:      floor_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // datapath write-back
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      c11_r  <= in_c11;
      c12_r  <= in_c12;
      c21_r  <= in_c21;
      c22_r  <= in_c22;
      dh_r   <= in_dh;
      n_r    <= NW'(in_c11) + NW'(in_c12) + NW'(in_c21) + NW'(in_c22) +
                (NW'(in_dh) << 1);
      iter_r <= '0;
      r2_r   <= '0;
      dp_r   <= '0;
    end
    if (state_r == S_FLOOR) begin
      before_r <= f11_r;
      f11_r    <= (f11_r > floor_w) ? f11_r : floor_w;
      f12_r    <= (f12_r > floor_w) ? f12_r : floor_w;
      f21_r    <= (f21_r > floor_w) ? f21_r : floor_w;
      f22_r    <= (f22_r > floor_w) ? f22_r : floor_w;
    end
    if (state_r == S_CHK) begin
      iter_r <= iter_r + 8'd1;
    end
    if (step_done) begin
      case (state_r)
        S_P:   p_r   <= quo;
        S_Q:   q_r   <= quo;
        S_F11: f11_r <= fm;
        S_F12: f12_r <= fm;
        S_F21: f21_r <= fm;
        S_F22: f22_r <= fm;
        S_T1:  t1_r  <= fm;
        S_T2:  t2_r  <= fm;
        S_S1:  s1_r  <= quo;
        S_S2:  s2_r  <= quo;
        S_M1:  ds1_r <= arith_rsp.res;
        S_M2:  ds2_r <= arith_rsp.res;
        S_D11: f11_r <= quo;
        S_D12: f12_r <= quo;
        S_D21: f21_r <= quo;
        S_D22: f22_r <= quo;
        S_X:   x_r   <= fm;
        S_Y: begin
          xgt_r  <= (x_r > fm);
          dabs_r <= (x_r > fm) ? (x_r - fm) : (fm - x_r);
        end
        S_DM1: tmp_r <= fm;
        S_DM2: dmx_r <= (tmp_r < fm) ? tmp_r : fm;
        S_DP:  dp_r  <= (quo < OUT_ONE) ? quo[31:0] : OUT_ONE[31:0];
        S_PP:  pp_r  <= fm;
        S_QQ:  qq_r  <= fm;
        S_DD:  tmp_r <= fm;
        S_T:   t_r   <= quo;
        S_R2:  r2_r  <= (quo < OUT_ONE) ? quo[30:0] : OUT_ONE[30:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {1'b0, dp_r, r2_r};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LDEM_ASSERT(a_idle_unit_free, (state_r == S_IDLE) |-> !arith_rsp.busy, "unit busy while idle")
  `LDEM_ASSERT(a_iter_bound, (state_r == S_CHK) |-> (iter_r < iter_limit_r), "iteration overrun")
  `LDEM_ASSERT(a_r2_sat, out_tvalid |-> (out_tdata[30:0] <= OUT_ONE[30:0]), "r2 above one")
  `LDEM_ASSERT_ALWAYS(a_dp_sat, out_tvalid |-> (!out_tdata[62] && !out_tdata[63]), "dprime sign")

endmodule
